// File: rtl/tree_ensemble_predict_assert.svh
// assertion macros for the tree ensemble predictor
// expects clk and rst_n in the scope where a macro is used
`ifndef TREE_ENSEMBLE_PREDICT_ASSERT_SVH
`define TREE_ENSEMBLE_PREDICT_ASSERT_SVH

// same-cycle implication
`define TEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tep assertion failed");

// next-cycle implication
`define TEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tep assertion failed");

`endif

// File: rtl/tep_pkg.sv
// sizes, codes and types of the tree ensemble predictor
// no dependencies
`default_nettype none

package tep_pkg;

    localparam int MAX_TREES    = 16;
    localparam int MAX_DEPTH    = 6;
    localparam int NUM_FEATURES = 64;
    localparam int MAX_OUTPUTS  = 4;

    localparam int NODES_PER_TREE = (2 ** (MAX_DEPTH + 1)) - 1;

    localparam int POS_W   = MAX_DEPTH + 1;
    localparam int TREE_W  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int TCNT_W  = $clog2(MAX_TREES + 1);
    localparam int DCNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int OUT_W   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int OCNT_W  = $clog2(MAX_OUTPUTS + 1);
    localparam int FEAT_AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

    localparam int FEAT_DEPTH = 2 ** FEAT_AW;
    localparam int NODE_AW    = TREE_W + POS_W;
    localparam int NODE_DEPTH = 2 ** NODE_AW;
    localparam int LEAF_AW    = NODE_AW + OUT_W;
    localparam int LEAF_DEPTH = 2 ** LEAF_AW;

    localparam int VALUE_W    = 32;
    localparam int NFEAT_W    = 7;
    localparam int PRED_W     = 36;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // opcodes of an input item
    localparam logic [1:0] OP_LOAD_FEATURE = 2'd0;
    localparam logic [1:0] OP_LOAD_NODE    = 2'd1;
    localparam logic [1:0] OP_LOAD_LEAF    = 2'd2;
    localparam logic [1:0] OP_PREDICT      = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TREES_IN_USE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS_IN_USE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT    = 8'd2;

    typedef logic [TREE_W-1:0]  tree_idx_t;
    typedef logic [TCNT_W-1:0]  tcnt_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [DCNT_W-1:0]  dcnt_t;
    typedef logic [OUT_W-1:0]   oidx_t;
    typedef logic [OCNT_W-1:0]  ocnt_t;
    typedef logic [FEAT_AW-1:0] feat_idx_t;
    typedef logic [NODE_AW-1:0] node_addr_t;
    typedef logic [LEAF_AW-1:0] leaf_addr_t;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [PRED_W-1:0]  pred_t;

    typedef struct packed {
        logic signed [NFEAT_W-1:0] feature;
        logic signed [VALUE_W-1:0] split;
    } node_word_t;

endpackage

`default_nettype wire

// File: rtl/tep_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tree_ensemble_predict.sv
// top level of the tree ensemble predictor: item decode, config, walk sequencer
// depends on tep_pkg, tep_ram and tree_ensemble_predict_assert.svh
`default_nettype none

// Inference for an ensemble of decision trees kept as implicit binary heaps
// (children of node p at 2p+1 and 2p+2). Load items (feature, node, leaf value)
// are written straight into their ram in the cycle they are accepted, so item_ready
// stays high after a load. A predict item walks each tree in use from the root
// with one node ram port, one feature ram port, one leaf ram port, one shared
// compare and one shared accumulator: a node step passes through S_NODE (node
// read), S_FEAT (feature read) and S_CMP (compare); a leaf mark is found in
// S_NODE and S_FEAT, the depth cap in S_NODE alone; every output of a tree
// passes through S_LEAF (leaf read) and S_ACC (accumulate). item_ready stays
// low until the last result is in the output register. Results leave through
// that register one per cycle while result_ready is high; last marks the final
// one. The rams start with undefined contents and get no clearing pass: every
// entry must be loaded before a predict reads it. cfg_ready is always high; the
// user must write configuration only while idle, which the block does not enforce.
module tree_ensemble_predict (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tep_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tep_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [1:0]                        opcode,
    input  wire logic [3:0]                        tree_number,
    input  wire logic [6:0]                        node_number,
    input  wire logic [5:0]                        feature_number,
    input  wire logic signed [tep_pkg::NFEAT_W-1:0] node_feature,
    input  wire logic signed [tep_pkg::VALUE_W-1:0] value,
    input  wire logic [1:0]                        output_number,

    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [1:0]                             output_column,
    output logic signed [tep_pkg::PRED_W-1:0]      prediction,
    output logic                                   last
);

`include "tree_ensemble_predict_assert.svh"

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_NODE  = 3'd2;
    localparam logic [2:0] S_FEAT  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_LEAF  = 3'd5;
    localparam logic [2:0] S_ACC   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    // configuration registers
    logic [4:0] trees_in_use_reg;
    logic [2:0] outputs_in_use_reg;
    logic [2:0] depth_limit_reg;

    // sequencer control
    logic [2:0]         state_reg, state_next;
    tep_pkg::tree_idx_t tree_reg, tree_next;
    tep_pkg::pos_t      pos_reg, pos_next;
    tep_pkg::dcnt_t     depth_reg, depth_next;
    tep_pkg::oidx_t     oidx_reg, oidx_next;
    logic               feat_zero_reg, feat_zero_next;

    // accumulators and output register
    tep_pkg::pred_t     sums_reg [tep_pkg::MAX_OUTPUTS];
    tep_pkg::pred_t     sums_next [tep_pkg::MAX_OUTPUTS];
    logic               result_valid_reg, result_valid_next;
    logic [1:0]         output_column_reg, output_column_next;
    tep_pkg::pred_t     prediction_reg, prediction_next;
    logic               last_reg, last_next;

    // clamped configuration
    tep_pkg::tcnt_t     ntrees;
    tep_pkg::dcnt_t     steps;
    tep_pkg::ocnt_t     nouts;

    logic item_fire;
    logic cfg_fire;

    // ram ports
    logic                         feat_we;
    logic                         feat_re;
    tep_pkg::feat_idx_t           feat_raddr;
    logic [tep_pkg::VALUE_W-1:0]  feat_rdata;

    logic                         node_we;
    logic                         node_re;
    tep_pkg::node_addr_t          node_waddr;
    tep_pkg::node_addr_t          node_raddr;
    tep_pkg::node_word_t          node_wdata;
    logic [$bits(tep_pkg::node_word_t)-1:0] node_rdata_raw;
    tep_pkg::node_word_t          node_word;

    logic                         leaf_we;
    logic                         leaf_re;
    tep_pkg::leaf_addr_t          leaf_waddr;
    tep_pkg::leaf_addr_t          leaf_raddr;
    logic [tep_pkg::VALUE_W-1:0]  leaf_rdata;

    // shared datapath
    tep_pkg::value_t    feat_x;
    logic               go_left;
    tep_pkg::pos_t      pos_shift;
    tep_pkg::pred_t     sum_sel;
    tep_pkg::pred_t     sum_add;
    logic               tree_last;
    logic               oidx_last;
    logic               emit_go;
    logic               emit_last;

    assign item_fire  = item_valid && item_ready;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_ready  = 1'b1;
    assign item_ready = (state_reg == S_IDLE);

    assign result_valid  = result_valid_reg;
    assign output_column = output_column_reg;
    assign prediction    = prediction_reg;
    assign last          = last_reg;

    // register clamps
    always_comb
    begin
        if (trees_in_use_reg > tep_pkg::MAX_TREES)
        begin
            ntrees = tep_pkg::tcnt_t'(tep_pkg::MAX_TREES);
        end
        else
        begin
            ntrees = tep_pkg::tcnt_t'(trees_in_use_reg);
        end

        if (depth_limit_reg > tep_pkg::MAX_DEPTH)
        begin
            steps = tep_pkg::dcnt_t'(tep_pkg::MAX_DEPTH);
        end
        else
        begin
            steps = tep_pkg::dcnt_t'(depth_limit_reg);
        end

        if (outputs_in_use_reg == 3'd0)
        begin
            nouts = tep_pkg::ocnt_t'(1);
        end
        else if (outputs_in_use_reg > tep_pkg::MAX_OUTPUTS)
        begin
            nouts = tep_pkg::ocnt_t'(tep_pkg::MAX_OUTPUTS);
        end
        else
        begin
            nouts = tep_pkg::ocnt_t'(outputs_in_use_reg);
        end
    end

    // load decode: out-of-range loads are dropped
    always_comb
    begin
        feat_we = 1'b0;
        node_we = 1'b0;
        leaf_we = 1'b0;
        if (item_fire)
        begin
            unique case (opcode)
                tep_pkg::OP_LOAD_FEATURE:
                begin
                    feat_we = (feature_number < tep_pkg::NUM_FEATURES);
                end
                tep_pkg::OP_LOAD_NODE:
                begin
                    node_we = (tree_number < tep_pkg::MAX_TREES)
                           && (node_number < tep_pkg::NODES_PER_TREE);
                end
                tep_pkg::OP_LOAD_LEAF:
                begin
                    leaf_we = (tree_number < tep_pkg::MAX_TREES)
                           && (node_number < tep_pkg::NODES_PER_TREE)
                           && (output_number < tep_pkg::MAX_OUTPUTS);
                end
                default:
                begin
                    // predict: handled by the sequencer
                end
            endcase
        end
    end

    // node slot is {tree, heap position}, leaf slot appends the output column
    assign node_waddr = {tep_pkg::tree_idx_t'(tree_number), tep_pkg::pos_t'(node_number)};
    assign leaf_waddr = {node_waddr, tep_pkg::oidx_t'(output_number)};
    assign node_wdata = '{feature: node_feature, split: value};

    assign node_raddr = {tree_reg, pos_reg};
    assign leaf_raddr = {tree_reg, pos_reg, oidx_reg};
    assign node_word  = tep_pkg::node_word_t'(node_rdata_raw);
    assign feat_raddr = tep_pkg::feat_idx_t'(unsigned'(node_word.feature));

    assign node_re = (state_reg == S_NODE) && (depth_reg != steps);
    assign feat_re = (state_reg == S_FEAT);
    assign leaf_re = (state_reg == S_LEAF);

    tep_ram #(
        .WIDTH (tep_pkg::VALUE_W),
        .DEPTH (tep_pkg::FEAT_DEPTH)
    ) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (tep_pkg::feat_idx_t'(feature_number)),
        .wdata (value),
        .re    (feat_re),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    tep_ram #(
        .WIDTH ($bits(tep_pkg::node_word_t)),
        .DEPTH (tep_pkg::NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata_raw)
    );

    tep_ram #(
        .WIDTH (tep_pkg::VALUE_W),
        .DEPTH (tep_pkg::LEAF_DEPTH)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (value),
        .re    (leaf_re),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    // shared compare: feature <= split goes left
    assign feat_x    = feat_zero_reg ? '0 : tep_pkg::value_t'(feat_rdata);
    assign go_left   = (feat_x <= node_word.split);
    assign pos_shift = tep_pkg::pos_t'({pos_reg, 1'b0});

    // shared accumulator over the selected output column
    assign sum_sel = sums_reg[oidx_reg];
    assign sum_add = sum_sel + tep_pkg::pred_t'(tep_pkg::value_t'(leaf_rdata));

    assign tree_last = (tep_pkg::tcnt_t'(tree_reg) + tep_pkg::tcnt_t'(1) == ntrees);
    assign oidx_last = (tep_pkg::ocnt_t'(oidx_reg) + tep_pkg::ocnt_t'(1) == nouts);

    // output register can take a result when empty or being drained
    assign emit_go   = (state_reg == S_EMIT) && (!result_valid_reg || result_ready);
    assign emit_last = oidx_last;

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        tree_next          = tree_reg;
        pos_next           = pos_reg;
        depth_next         = depth_reg;
        oidx_next          = oidx_reg;
        feat_zero_next     = feat_zero_reg;
        sums_next          = sums_reg;
        result_valid_next  = result_valid_reg && !result_ready;
        output_column_next = output_column_reg;
        prediction_next    = prediction_reg;
        last_next          = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire && opcode == tep_pkg::OP_PREDICT)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                for (int j = 0; j < tep_pkg::MAX_OUTPUTS; j++)
                begin
                    sums_next[j] = '0;
                end
                tree_next  = '0;
                pos_next   = '0;
                depth_next = '0;
                oidx_next  = '0;
                if (ntrees == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_NODE;
                end
            end
            S_NODE:
            begin
                // node read issued unless the depth cap is reached
                oidx_next = '0;
                if (depth_reg == steps)
                begin
                    state_next = S_LEAF;
                end
                else
                begin
                    state_next = S_FEAT;
                end
            end
            S_FEAT:
            begin
                // any negative feature marks a leaf
                feat_zero_next = (int'(node_word.feature) >= tep_pkg::NUM_FEATURES);
                if (node_word.feature[tep_pkg::NFEAT_W-1])
                begin
                    state_next = S_LEAF;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (go_left)
                begin
                    pos_next = pos_shift + tep_pkg::pos_t'(1);
                end
                else
                begin
                    pos_next = pos_shift + tep_pkg::pos_t'(2);
                end
                depth_next = depth_reg + tep_pkg::dcnt_t'(1);
                state_next = S_NODE;
            end
            S_LEAF:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sums_next[oidx_reg] = sum_add;
                if (!oidx_last)
                begin
                    oidx_next  = oidx_reg + tep_pkg::oidx_t'(1);
                    state_next = S_LEAF;
                end
                else if (tree_last)
                begin
                    oidx_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    tree_next  = tree_reg + tep_pkg::tree_idx_t'(1);
                    pos_next   = '0;
                    depth_next = '0;
                    state_next = S_NODE;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    result_valid_next  = 1'b1;
                    output_column_next = 2'(oidx_reg);
                    prediction_next    = sum_sel;
                    last_next          = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + tep_pkg::oidx_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trees_in_use_reg   <= 5'd1;
            outputs_in_use_reg <= 3'd1;
            depth_limit_reg    <= 3'd6;
            state_reg          <= S_IDLE;
            tree_reg           <= '0;
            pos_reg            <= '0;
            depth_reg          <= '0;
            oidx_reg           <= '0;
            feat_zero_reg      <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    tep_pkg::CFG_TREES_IN_USE:
                    begin
                        trees_in_use_reg <= cfg_data[4:0];
                    end
                    tep_pkg::CFG_OUTPUTS_IN_USE:
                    begin
                        outputs_in_use_reg <= cfg_data[2:0];
                    end
                    tep_pkg::CFG_DEPTH_LIMIT:
                    begin
                        depth_limit_reg <= cfg_data[2:0];
                    end
                    default:
                    begin
                        // unused index
                    end
                endcase
            end
            state_reg        <= state_next;
            tree_reg         <= tree_next;
            pos_reg          <= pos_next;
            depth_reg        <= depth_next;
            oidx_reg         <= oidx_next;
            feat_zero_reg    <= feat_zero_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sums_reg          <= sums_next;
        output_column_reg <= output_column_next;
        prediction_reg    <= prediction_next;
        last_reg          <= last_next;
    end

    // checks
    `TEP_ASSERT_NEXT(a_predict_starts, item_fire && opcode == tep_pkg::OP_PREDICT,
        state_reg == S_START)
    `TEP_ASSERT_NOW(a_depth_bound,
        state_reg == S_NODE || state_reg == S_FEAT || state_reg == S_CMP,
        depth_reg <= steps)
    `TEP_ASSERT_NOW(a_tree_bound,
        state_reg == S_NODE || state_reg == S_LEAF || state_reg == S_ACC,
        tep_pkg::tcnt_t'(tree_reg) < ntrees)
    `TEP_ASSERT_NOW(a_output_bound,
        state_reg == S_LEAF || state_reg == S_ACC || state_reg == S_EMIT,
        tep_pkg::ocnt_t'(oidx_reg) < nouts)
    `TEP_ASSERT_NEXT(a_last_ends, emit_go && emit_last,
        state_reg == S_IDLE && result_valid_reg && last_reg)

endmodule

`default_nettype wire
